### rtl/bra_pkg.sv
`default_nettype none

package bra_pkg;

   localparam int unsigned StampWidth = 32;

   localparam logic [1:0] REQ_START = 2'd0;
   localparam logic [1:0] REQ_EVENT = 2'd1;
   localparam logic [1:0] REQ_END   = 2'd2;

   localparam logic [3:0] EV_GAS_ON       = 4'd0;
   localparam logic [3:0] EV_GAS_OFF      = 4'd1;
   localparam logic [3:0] EV_PELLET_ON    = 4'd2;
   localparam logic [3:0] EV_PELLET_OFF   = 4'd3;
   localparam logic [3:0] EV_MINIMUM      = 4'd4;
   localparam logic [3:0] EV_MODULATION   = 4'd5;
   localparam logic [3:0] EV_FLAMEOUT_ON  = 4'd6;
   localparam logic [3:0] EV_FLAMEOUT_OFF = 4'd7;
   localparam logic [3:0] EV_HOT          = 4'd8;
   localparam logic [3:0] EV_COLD         = 4'd9;

   typedef struct packed {
      logic [1:0]            req_type;
      logic [StampWidth-1:0] stamp;
      logic [3:0]            event_code;
      logic                  init_pellet_on;
      logic                  init_minimum_on;
      logic                  init_gas_on;
      logic                  init_flameout;
      logic [StampWidth-1:0] init_pellet_seconds;
      logic [StampWidth-1:0] init_low_seconds;
      logic [StampWidth-1:0] init_gas_seconds;
   } bra_req_type;

   typedef struct packed {
      logic [StampWidth-1:0] pellet_seconds;
      logic [StampWidth-1:0] low_seconds;
      logic [StampWidth-1:0] gas_seconds;
      logic                  final_pellet_on;
      logic                  final_minimum_on;
      logic                  final_gas_on;
      logic                  final_flameout;
   } bra_rsp_type;

endpackage

`default_nettype wire

### rtl/burner_runtime_accumulator.sv
// Each beat is captured in the input register; an end beat loads the output register.
// Throughput: one beat per cycle while no end beat waits behind a held result; each
// beat updates the running state through a single subtract and add per accumulator.
// The input and output registers decouple the two sides; a held result stalls only an
// end beat behind it. Synchronous reset zeroes the valid bits and running state.
`default_nettype none

module burner_runtime_accumulator (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_ready,
   input  bra_pkg::bra_req_type req_data,
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   output bra_pkg::bra_rsp_type rsp_data
);
   import bra_pkg::*;

   localparam int unsigned FlPellet = 0;
   localparam int unsigned FlMin    = 1;
   localparam int unsigned FlGas    = 2;
   localparam int unsigned FlFlame  = 3;
   localparam int unsigned FlWasOn  = 4;
   localparam int unsigned FlHot    = 5;

   bra_req_type           item_ff;
   logic                  item_valid_ff, item_valid_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   bra_rsp_type           rsp_data_ff, rsp_data_in;

   logic [StampWidth-1:0] pellet_since_ff, pellet_since_in;
   logic [StampWidth-1:0] low_since_ff, low_since_in;
   logic [StampWidth-1:0] gas_since_ff, gas_since_in;
   logic [StampWidth-1:0] pellet_total_ff, pellet_total_in;
   logic [StampWidth-1:0] low_total_ff, low_total_in;
   logic [StampWidth-1:0] gas_total_ff, gas_total_in;
   logic [5:0]            flags_ff, flags_in;

   logic                  item_is_end;
   logic                  advance;
   logic                  req_accept;

   assign item_is_end = (item_ff.req_type == REQ_END);
   assign advance     = item_valid_ff && (!item_is_end || !rsp_valid_ff || rsp_ready);
   assign req_ready   = !item_valid_ff || advance;
   assign req_accept  = req_valid && req_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_data    = rsp_data_ff;

   always_comb begin
      item_valid_in = item_valid_ff;
      if (req_accept) begin
         item_valid_in = 1'b1;
      end else if (advance) begin
         item_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance && item_is_end) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      logic [StampWidth-1:0] t;
      logic                  flame;
      t     = item_ff.stamp;
      flame = flags_ff[FlFlame];

      pellet_since_in = pellet_since_ff;
      low_since_in    = low_since_ff;
      gas_since_in    = gas_since_ff;
      pellet_total_in = pellet_total_ff;
      low_total_in    = low_total_ff;
      gas_total_in    = gas_total_ff;
      flags_in        = flags_ff;

      case (item_ff.req_type)
         REQ_START: begin
            flags_in        = {2'b00, item_ff.init_flameout, item_ff.init_gas_on,
                               item_ff.init_minimum_on, item_ff.init_pellet_on};
            pellet_total_in = item_ff.init_pellet_seconds;
            low_total_in    = item_ff.init_low_seconds;
            gas_total_in    = item_ff.init_gas_seconds;
            pellet_since_in = item_ff.init_pellet_on ? t : '0;
            low_since_in    = (item_ff.init_pellet_on && item_ff.init_minimum_on) ? t : '0;
            gas_since_in    = item_ff.init_gas_on ? t : '0;
         end
         REQ_EVENT: begin
            case (item_ff.event_code)
               EV_GAS_ON: begin
                  if (gas_since_ff == '0 && !flags_ff[FlHot]) begin
                     gas_since_in = t;
                  end
                  flags_in[FlGas] = 1'b1;
               end
               EV_GAS_OFF: begin
                  if (gas_since_ff != '0) begin
                     gas_total_in = gas_total_ff + (t - gas_since_ff);
                     gas_since_in = '0;
                  end
                  flags_in[FlGas] = 1'b0;
               end
               EV_PELLET_ON: begin
                  if (!flame) begin
                     if (pellet_since_ff == '0) begin
                        pellet_since_in = t;
                        if (flags_ff[FlMin]) begin
                           low_since_in = t;
                        end
                     end
                     flags_in[FlPellet] = 1'b1;
                  end
               end
               EV_PELLET_OFF, EV_FLAMEOUT_ON: begin
                  if (pellet_since_ff != '0) begin
                     pellet_total_in = pellet_total_ff + (t - pellet_since_ff);
                     pellet_since_in = '0;
                  end
                  if (low_since_ff != '0) begin
                     low_total_in = low_total_ff + (t - low_since_ff);
                     low_since_in = '0;
                  end
                  flags_in[FlPellet] = 1'b0;
                  if (item_ff.event_code == EV_FLAMEOUT_ON) begin
                     flags_in[FlWasOn] = flags_ff[FlPellet];
                     flags_in[FlFlame] = 1'b1;
                  end else begin
                     flags_in[FlWasOn] = 1'b0;
                  end
               end
               EV_MINIMUM: begin
                  flags_in[FlMin] = 1'b1;
                  if (!flame && pellet_since_ff != '0 && low_since_ff == '0) begin
                     low_since_in = t;
                  end
               end
               EV_MODULATION: begin
                  flags_in[FlMin] = 1'b0;
                  if (!flame && low_since_ff != '0) begin
                     low_total_in = low_total_ff + (t - low_since_ff);
                     low_since_in = '0;
                  end
               end
               EV_FLAMEOUT_OFF: begin
                  flags_in[FlFlame] = 1'b0;
                  if (flags_ff[FlWasOn]) begin
                     pellet_since_in    = t;
                     flags_in[FlPellet] = 1'b1;
                     if (flags_ff[FlMin]) begin
                        low_since_in = t;
                     end
                  end
               end
               EV_HOT: begin
                  if (flame) begin
                     pellet_since_in    = t;
                     flags_in[FlPellet] = 1'b1;
                     flags_in[FlFlame]  = 1'b0;
                     if (flags_ff[FlMin]) begin
                        low_since_in = t;
                     end
                  end
                  flags_in[FlHot] = 1'b1;
                  if (gas_since_ff != '0) begin
                     gas_total_in = gas_total_ff + (t - gas_since_ff);
                     gas_since_in = '0;
                  end
                  flags_in[FlGas] = 1'b0;
               end
               EV_COLD: begin
                  flags_in[FlHot] = 1'b0;
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      logic [StampWidth-1:0] t;
      t = item_ff.stamp;
      rsp_data_in.pellet_seconds   = pellet_total_ff +
                                     (flags_ff[FlPellet] ? (t - pellet_since_ff) : '0);
      rsp_data_in.low_seconds      = low_total_ff +
                                     ((flags_ff[FlPellet] && flags_ff[FlMin]) ?
                                      (t - low_since_ff) : '0);
      rsp_data_in.gas_seconds      = gas_total_ff +
                                     (flags_ff[FlGas] ? (t - gas_since_ff) : '0);
      rsp_data_in.final_pellet_on  = flags_ff[FlPellet];
      rsp_data_in.final_minimum_on = flags_ff[FlMin];
      rsp_data_in.final_gas_on     = flags_ff[FlGas];
      rsp_data_in.final_flameout   = flags_ff[FlFlame];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         pellet_since_ff <= '0;
         low_since_ff    <= '0;
         gas_since_ff    <= '0;
         pellet_total_ff <= '0;
         low_total_ff    <= '0;
         gas_total_ff    <= '0;
         flags_ff        <= '0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (advance) begin
            pellet_since_ff <= pellet_since_in;
            low_since_ff    <= low_since_in;
            gas_since_ff    <= gas_since_in;
            pellet_total_ff <= pellet_total_in;
            low_total_ff    <= low_total_in;
            gas_total_ff    <= gas_total_in;
            flags_ff        <= flags_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff <= req_data;
      end
      if (advance && item_is_end) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // A new result beat only ever follows an end-of-interval beat leaving the input register.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !$past(rsp_valid_ff) |->
         $past(item_valid_ff && item_ff.req_type == REQ_END))
      else $error("result beat without an end beat");

   // An end beat behind a held result must stall the input side.
   assert property (@(posedge clock) disable iff (reset)
      item_valid_ff && item_is_end && rsp_valid_ff && !rsp_ready |-> !req_ready)
      else $error("input accepted while end beat is blocked");

   // The output register is empty right after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("result beat pending after reset");

endmodule

`default_nettype wire
